### hw/rtl/n2c_pkg.sv
// Shared constants, codes and interface types of the normalized 2D convolution block.
package n2c_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_MASK   = 15;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_ROWS  = 2 * MAX_MASK + 2;
    localparam int COEF_COUNT = MAX_MASK * MAX_MASK;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int IW_W    = 11;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int IH_W    = 13;
    localparam int MSK_W   = 4;
    localparam int LROW_W  = $clog2(LINE_ROWS);
    localparam int LADDR_W = LROW_W + COL_W;
    localparam int CIDX_W  = 8;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int ACC_W   = 32;
    localparam int WSUM_W  = 24;
    localparam int QUO_W   = 16;
    localparam int QCNT_W  = $clog2(QUO_W);

    typedef enum logic [1:0] {
        ACT_COEF  = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MASK_WIDTH   = 3'd2,
        REG_MASK_HEIGHT  = 3'd3,
        REG_ANCHOR_X     = 3'd4,
        REG_ANCHOR_Y     = 3'd5,
        REG_SPARE6       = 3'd6,
        REG_SPARE7       = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TAPS,
        ST_DRAIN,
        ST_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Clamped configuration as the datapath uses it.
    typedef struct packed {
        logic [IW_W-1:0]  iw;
        logic [IH_W-1:0]  ih;
        logic [MSK_W-1:0] mw;
        logic [MSK_W-1:0] mh;
        logic [MSK_W-1:0] ax;
        logic [MSK_W-1:0] ay;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic tap_init;
        logic tap_step;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic item_ready;
        logic tap_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/n2c_regs.sv
// Configuration register file with APB-style access and range clamping.
module n2c_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output n2c_pkg::cfg_t        cfg,
    output logic                 cfg_wr
);

    logic [n2c_pkg::IW_W-1:0]  iw_reg;
    logic [n2c_pkg::IH_W-1:0]  ih_reg;
    logic [n2c_pkg::MSK_W-1:0] mw_reg;
    logic [n2c_pkg::MSK_W-1:0] mh_reg;
    logic [n2c_pkg::MSK_W-1:0] ax_reg;
    logic [n2c_pkg::MSK_W-1:0] ay_reg;
    logic                      wr;
    n2c_pkg::reg_index_t       idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = n2c_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg <= n2c_pkg::IW_W'(640);
            ih_reg <= n2c_pkg::IH_W'(480);
            mw_reg <= n2c_pkg::MSK_W'(3);
            mh_reg <= n2c_pkg::MSK_W'(3);
            ax_reg <= n2c_pkg::MSK_W'(1);
            ay_reg <= n2c_pkg::MSK_W'(1);
        end else if (wr) begin
            unique case (idx)
                n2c_pkg::REG_IMAGE_WIDTH:  iw_reg <= pwdata[n2c_pkg::IW_W-1:0];
                n2c_pkg::REG_IMAGE_HEIGHT: ih_reg <= pwdata[n2c_pkg::IH_W-1:0];
                n2c_pkg::REG_MASK_WIDTH:   mw_reg <= pwdata[n2c_pkg::MSK_W-1:0];
                n2c_pkg::REG_MASK_HEIGHT:  mh_reg <= pwdata[n2c_pkg::MSK_W-1:0];
                n2c_pkg::REG_ANCHOR_X:     ax_reg <= pwdata[n2c_pkg::MSK_W-1:0];
                n2c_pkg::REG_ANCHOR_Y:     ay_reg <= pwdata[n2c_pkg::MSK_W-1:0];
                default: ;
            endcase
        end
    end

    // A write to a listed register starts a new frame.
    assign cfg_wr = wr && (idx != n2c_pkg::REG_SPARE6) && (idx != n2c_pkg::REG_SPARE7);

    always_comb begin
        unique case (idx)
            n2c_pkg::REG_IMAGE_WIDTH:  prdata = 32'(iw_reg);
            n2c_pkg::REG_IMAGE_HEIGHT: prdata = 32'(ih_reg);
            n2c_pkg::REG_MASK_WIDTH:   prdata = 32'(mw_reg);
            n2c_pkg::REG_MASK_HEIGHT:  prdata = 32'(mh_reg);
            n2c_pkg::REG_ANCHOR_X:     prdata = 32'(ax_reg);
            n2c_pkg::REG_ANCHOR_Y:     prdata = 32'(ay_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (iw_reg == '0) begin
            cfg.iw = n2c_pkg::IW_W'(1);
        end else if (iw_reg > n2c_pkg::IW_W'(n2c_pkg::MAX_WIDTH)) begin
            cfg.iw = n2c_pkg::IW_W'(n2c_pkg::MAX_WIDTH);
        end else begin
            cfg.iw = iw_reg;
        end
        if (ih_reg == '0) begin
            cfg.ih = n2c_pkg::IH_W'(1);
        end else if (ih_reg > n2c_pkg::IH_W'(n2c_pkg::MAX_HEIGHT)) begin
            cfg.ih = n2c_pkg::IH_W'(n2c_pkg::MAX_HEIGHT);
        end else begin
            cfg.ih = ih_reg;
        end
        cfg.mw = (mw_reg == '0) ? n2c_pkg::MSK_W'(1) : mw_reg;
        cfg.mh = (mh_reg == '0) ? n2c_pkg::MSK_W'(1) : mh_reg;
        cfg.ax = ax_reg;
        cfg.ay = ay_reg;
    end

endmodule

### hw/rtl/n2c_ctrl.sv
// Sequencing state machine: item intake, tap walk, division and result hand-off.
module n2c_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  n2c_pkg::action_t    action,
    input  n2c_pkg::sts_t       sts,
    output n2c_pkg::cmd_t       cmd
);

    n2c_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= n2c_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            n2c_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (action == n2c_pkg::ACT_PIXEL || action == n2c_pkg::ACT_FLUSH) begin
                        state_next = n2c_pkg::ST_CHECK;
                    end
                end
            end
            n2c_pkg::ST_CHECK: begin
                if (sts.item_ready) begin
                    cmd.tap_init = 1'b1;
                    state_next   = n2c_pkg::ST_TAPS;
                end else begin
                    state_next = n2c_pkg::ST_IDLE;
                end
            end
            n2c_pkg::ST_TAPS: begin
                cmd.tap_step = 1'b1;
                if (sts.tap_last) begin
                    state_next = n2c_pkg::ST_DRAIN;
                end
            end
            // The last tap read is summed at the end of this cycle.
            n2c_pkg::ST_DRAIN: state_next = n2c_pkg::ST_LOAD;
            n2c_pkg::ST_LOAD: begin
                cmd.div_init = 1'b1;
                state_next   = n2c_pkg::ST_DIVIDE;
            end
            n2c_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = n2c_pkg::ST_EMIT;
                end
            end
            n2c_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = n2c_pkg::ST_IDLE;
                end
            end
            default: state_next = n2c_pkg::ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/n2c_dp.sv
// Datapath: line and coefficient stores, frame counters, tap accumulator, divider, output register.
module n2c_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  n2c_pkg::cfg_t                 cfg,
    input  logic                          cfg_wr,
    input  n2c_pkg::cmd_t                 cmd,
    output n2c_pkg::sts_t                 sts,
    input  n2c_pkg::action_t              action,
    input  logic [n2c_pkg::CIDX_W-1:0]    coef_index,
    input  logic [n2c_pkg::COEF_W-1:0]    coef_value,
    input  logic [n2c_pkg::PIX_W-1:0]     pixel,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [n2c_pkg::QUO_W-1:0]     m_out_value,
    output logic                          m_no_weight,
    output logic                          m_frame_last
);

    localparam int QS_W  = n2c_pkg::IH_W + 1;
    localparam int PS_W  = n2c_pkg::IW_W + 1;
    localparam int NUM_W = n2c_pkg::ACC_W + 8;

    logic [n2c_pkg::PIX_W-1:0]  line_mem [n2c_pkg::LINE_ROWS * n2c_pkg::MAX_WIDTH];
    logic [n2c_pkg::COEF_W-1:0] coef_mem [n2c_pkg::COEF_COUNT];

    logic [n2c_pkg::COL_W-1:0]  in_col_reg, out_col_reg;
    logic [n2c_pkg::IH_W-1:0]   in_row_reg;
    logic [n2c_pkg::ROW_W-1:0]  out_row_reg;
    logic [n2c_pkg::MSK_W-1:0]  tap_n_reg, tap_m_reg;
    logic [n2c_pkg::CIDX_W-1:0] cidx_reg, cbase_reg;
    logic                       tvld_reg;
    logic [n2c_pkg::PIX_W-1:0]  pix_q_reg;
    logic [n2c_pkg::COEF_W-1:0] coef_q_reg;
    logic [n2c_pkg::ACC_W-1:0]  acc_reg;
    logic [n2c_pkg::WSUM_W-1:0] wsum_reg;
    logic [n2c_pkg::WSUM_W-1:0] rem_reg;
    logic [n2c_pkg::QUO_W-1:0]  dq_reg;
    logic [n2c_pkg::QCNT_W-1:0] dcnt_reg;
    logic                       m_tvalid_reg;

    logic                       pix_we, coef_we, col_wrap, out_wrap, fl;
    logic [n2c_pkg::IW_W-1:0]   in_col_inc, out_col_inc, iw_m1, pmax_raw, pmax;
    logic [n2c_pkg::IH_W-1:0]   ih_m1, qmax_raw, qmax;
    logic [4:0]                 rx_full, ry_full;
    logic [n2c_pkg::MSK_W-1:0]  rx, ry;
    logic [QS_W-1:0]            q_s;
    logic [PS_W-1:0]            p_s;
    logic                       in_q, in_p, row_end;
    logic [n2c_pkg::LADDR_W-1:0] rd_addr, wr_addr;
    logic [NUM_W-1:0]           num;
    logic [n2c_pkg::WSUM_W:0]   trial, diff;
    logic                       ge;

    assign iw_m1 = cfg.iw - n2c_pkg::IW_W'(1);
    assign ih_m1 = cfg.ih - n2c_pkg::IH_W'(1);

    assign pix_we  = cmd.accept && (action == n2c_pkg::ACT_PIXEL) && (in_row_reg < cfg.ih);
    assign coef_we = cmd.accept && (action == n2c_pkg::ACT_COEF)
                     && (coef_index < n2c_pkg::CIDX_W'(n2c_pkg::COEF_COUNT));

    assign in_col_inc  = {1'b0, in_col_reg} + n2c_pkg::IW_W'(1);
    assign col_wrap    = in_col_inc >= cfg.iw;
    assign out_col_inc = {1'b0, out_col_reg} + n2c_pkg::IW_W'(1);
    assign out_wrap    = out_col_inc >= cfg.iw;
    assign fl          = ({1'b0, out_col_reg} == iw_m1) && ({1'b0, out_row_reg} == ih_m1);

    // Readiness: the last input pixel that the next output needs has arrived.
    assign rx_full  = {1'b0, cfg.mw} - {1'b0, cfg.ax} - 5'd1;
    assign ry_full  = {1'b0, cfg.mh} - {1'b0, cfg.ay} - 5'd1;
    assign rx       = rx_full[4] ? '0 : rx_full[3:0];
    assign ry       = ry_full[4] ? '0 : ry_full[3:0];
    assign pmax_raw = {1'b0, out_col_reg} + n2c_pkg::IW_W'(rx);
    assign qmax_raw = {1'b0, out_row_reg} + n2c_pkg::IH_W'(ry);
    assign pmax     = (pmax_raw > iw_m1) ? iw_m1 : pmax_raw;
    assign qmax     = (qmax_raw > ih_m1) ? ih_m1 : qmax_raw;

    assign sts.item_ready = (in_row_reg >= cfg.ih) || (in_row_reg > qmax)
                            || ((in_row_reg == qmax) && ({1'b0, in_col_reg} > pmax));

    // Tap position in the image; rows wrap around the line ring.
    assign q_s = QS_W'(out_row_reg) + QS_W'(tap_n_reg) - QS_W'(cfg.ay);
    assign p_s = PS_W'(out_col_reg) + PS_W'(tap_m_reg) - PS_W'(cfg.ax);
    assign in_q = !q_s[QS_W-1] && (q_s[n2c_pkg::IH_W-1:0] < cfg.ih);
    assign in_p = !p_s[PS_W-1] && (p_s[n2c_pkg::IW_W-1:0] < cfg.iw);
    assign rd_addr = {q_s[n2c_pkg::LROW_W-1:0], p_s[n2c_pkg::COL_W-1:0]};
    assign wr_addr = {in_row_reg[n2c_pkg::LROW_W-1:0], in_col_reg};
    assign row_end = tap_m_reg == (cfg.mw - n2c_pkg::MSK_W'(1));

    assign sts.tap_last = row_end && (tap_n_reg == (cfg.mh - n2c_pkg::MSK_W'(1)));
    assign sts.div_last = dcnt_reg == n2c_pkg::QCNT_W'(n2c_pkg::QUO_W - 1);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            line_mem[wr_addr] <= pixel;
        end
        pix_q_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_index] <= coef_value;
        end
        coef_q_reg <= coef_mem[cidx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_wr || (cmd.emit && fl)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (pix_we) begin
                if (col_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + n2c_pkg::IH_W'(1);
                end else begin
                    in_col_reg <= in_col_inc[n2c_pkg::COL_W-1:0];
                end
            end
            if (cmd.emit) begin
                if (out_wrap) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + n2c_pkg::ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_inc[n2c_pkg::COL_W-1:0];
                end
            end
        end
    end

    // Tap walk over the mask, one coefficient per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvld_reg <= 1'b0;
        end else begin
            tvld_reg <= cmd.tap_step && in_q && in_p;
        end
        if (cmd.tap_init) begin
            tap_n_reg <= '0;
            tap_m_reg <= '0;
            cidx_reg  <= '0;
            cbase_reg <= '0;
        end else if (cmd.tap_step) begin
            if (row_end) begin
                tap_m_reg <= '0;
                tap_n_reg <= tap_n_reg + n2c_pkg::MSK_W'(1);
                cbase_reg <= cbase_reg + n2c_pkg::CIDX_W'(n2c_pkg::MAX_MASK);
                cidx_reg  <= cbase_reg + n2c_pkg::CIDX_W'(n2c_pkg::MAX_MASK);
            end else begin
                tap_m_reg <= tap_m_reg + n2c_pkg::MSK_W'(1);
                cidx_reg  <= cidx_reg + n2c_pkg::CIDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tap_init) begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end else if (tvld_reg) begin
            acc_reg  <= acc_reg + n2c_pkg::ACC_W'(pix_q_reg) * n2c_pkg::ACC_W'(coef_q_reg);
            wsum_reg <= wsum_reg + n2c_pkg::WSUM_W'(coef_q_reg);
        end
    end

    // Restoring division, one quotient bit per cycle. The quotient never
    // exceeds 16 bits, so the upper numerator bits start below the divisor.
    assign num   = {acc_reg, 8'd0} + NUM_W'(wsum_reg >> 1);
    assign trial = {rem_reg, dq_reg[n2c_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, wsum_reg};
    assign ge    = trial >= {1'b0, wsum_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg  <= num[NUM_W-1 -: n2c_pkg::WSUM_W];
            dq_reg   <= num[n2c_pkg::QUO_W-1:0];
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= ge ? diff[n2c_pkg::WSUM_W-1:0] : trial[n2c_pkg::WSUM_W-1:0];
            dq_reg   <= {dq_reg[n2c_pkg::QUO_W-2:0], ge};
            dcnt_reg <= dcnt_reg + n2c_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_out_value  <= (wsum_reg == '0) ? '0 : dq_reg;
            m_no_weight  <= wsum_reg == '0;
            m_frame_last <= fl;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

### hw/rtl/normalized_2d_convolution.sv
// Top level of the normalized 2D convolution block.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser = action; tdata = coef_index, coef_value, pixel
//  m_axis    out        tdata = out_value; tuser = no_weight; tlast = frame_last
//  apb       in/out     six configuration registers at byte addresses 0..20
//
// A coefficient load is written in IDLE. A pixel or flush that yields no output
// passes IDLE and CHECK; one that yields an output also walks each mask tap
// through the single read port of the line store (one tap per cycle) and the
// bit-serial 16-step divider. Reset is synchronous and active low and
// clears counters and handshakes; the stores are not cleared. A new item is
// taken while a result waits in the output register; the block stalls only
// when a second result is ready before the first transfer completes.
module normalized_2d_convolution (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // coef_index[7:0], coef_value[23:8], pixel[31:24]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_value[15:0]
    output logic        m_tuser,   // no_weight[0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    n2c_pkg::cfg_t    cfg;
    logic             cfg_wr;
    n2c_pkg::cmd_t    cmd;
    n2c_pkg::sts_t    sts;
    n2c_pkg::action_t action;

    assign action = n2c_pkg::action_t'(s_tuser);

    n2c_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    n2c_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    n2c_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cfg_wr       (cfg_wr),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .coef_index   (s_tdata[7:0]),
        .coef_value   (s_tdata[23:8]),
        .pixel        (s_tdata[31:24]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_out_value  (m_tdata),
        .m_no_weight  (m_tuser),
        .m_frame_last (m_tlast)
    );

endmodule

### verif/tb.sv
// Self-checking testbench for the normalized 2D convolution block.
import n2c_pkg::*;

typedef struct {
    logic [15:0] value;
    logic        no_weight;
    logic        last;
} conv_result_t;

class conv_scoreboard;
    bit [7:0]     line_pix [LINE_ROWS*MAX_WIDTH];
    bit [15:0]    coefs [COEF_COUNT];
    int unsigned  in_col, in_row, out_col, out_row;
    int unsigned  reg_iw, reg_ih, reg_mw, reg_mh, reg_ax, reg_ay;
    bit           frame_open;
    conv_result_t pending [$];
    int           mismatches;

    function new();
        reg_iw = 640; reg_ih = 480; reg_mw = 3; reg_mh = 3; reg_ax = 1; reg_ay = 1;
        mismatches = 0;
        clear_counters();
    endfunction

    function int unsigned clampv(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function void clear_counters();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        frame_open = 0;
    endfunction

    function void write_reg(reg_index_t idx, bit [31:0] data);
        int unsigned v;
        v = data & 32'h1FFF;
        case (idx)
            REG_IMAGE_WIDTH:  reg_iw = v & 32'h7FF;
            REG_IMAGE_HEIGHT: reg_ih = v;
            REG_MASK_WIDTH:   reg_mw = v & 32'hF;
            REG_MASK_HEIGHT:  reg_mh = v & 32'hF;
            REG_ANCHOR_X:     reg_ax = v & 32'hF;
            REG_ANCHOR_Y:     reg_ay = v & 32'hF;
            default:          return;
        endcase
        clear_counters();
    endfunction

    function bit out_ready(int unsigned iw, int unsigned ih, int unsigned mw, int unsigned mh);
        int          rx, ry;
        longint      pmax, qmax;
        if (in_row >= ih) return 1;
        rx = int'(mw) - 1 - int'(reg_ax);
        ry = int'(mh) - 1 - int'(reg_ay);
        if (rx < 0) rx = 0;
        if (ry < 0) ry = 0;
        pmax = longint'(out_col) + rx;
        qmax = longint'(out_row) + ry;
        if (pmax > iw - 1) pmax = iw - 1;
        if (qmax > ih - 1) qmax = ih - 1;
        return longint'(in_row) * iw + in_col > qmax * iw + pmax;
    endfunction

    // Called for every accepted input transfer.
    function void note(action_t act, bit [7:0] idx, bit [15:0] cv, bit [7:0] pix);
        int unsigned     iw, ih, mw, mh, col;
        longint unsigned acc, wsum;
        int              q, p;
        conv_result_t    r;
        iw = clampv(reg_iw, MAX_WIDTH);
        ih = clampv(reg_ih, MAX_HEIGHT);
        mw = clampv(reg_mw, MAX_MASK);
        mh = clampv(reg_mh, MAX_MASK);
        if (act == ACT_COEF) begin
            if (idx < COEF_COUNT) coefs[idx] = cv;
            return;
        end
        if (act == ACT_NONE) return;
        if (act == ACT_PIXEL && in_row < ih) begin
            col = (in_col < iw) ? in_col : iw - 1;
            line_pix[(in_row % LINE_ROWS) * MAX_WIDTH + col] = pix;
            frame_open = 1;
            in_col++;
            if (in_col >= iw) begin
                in_col = 0;
                in_row++;
            end
        end
        if (!out_ready(iw, ih, mw, mh)) return;
        acc = 0;
        wsum = 0;
        for (int n = 0; n < mh; n++) begin
            q = int'(out_row) + n - int'(reg_ay);
            if (q < 0 || q >= int'(ih)) continue;
            for (int m = 0; m < mw; m++) begin
                p = int'(out_col) + m - int'(reg_ax);
                if (p < 0 || p >= int'(iw)) continue;
                acc += line_pix[(q % LINE_ROWS) * MAX_WIDTH + p] * coefs[n * MAX_MASK + m];
                wsum += coefs[n * MAX_MASK + m];
            end
        end
        if (wsum == 0) begin
            r.value = 0;
            r.no_weight = 1;
        end else begin
            r.value = 16'((acc * 256 + wsum / 2) / wsum);
            r.no_weight = 0;
        end
        r.last = (out_col == iw - 1 && out_row == ih - 1);
        pending.push_back(r);
        if (r.last) begin
            clear_counters();
        end else begin
            out_col++;
            if (out_col >= iw) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function void check(logic [15:0] value, logic no_weight, logic last);
        conv_result_t e;
        if (pending.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: value %h no_weight %b last %b",
                         value, no_weight, last);
            mismatches++;
            return;
        end
        e = pending.pop_front();
        if (value !== e.value || no_weight !== e.no_weight || last !== e.last) begin
            if (mismatches < 10)
                $display("mismatch: expected value %h no_weight %b last %b, got %h %b %b",
                         e.value, e.no_weight, e.last, value, no_weight, last);
            mismatches++;
        end
    endfunction
endclass

module tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;   // coef_index[7:0], coef_value[23:8], pixel[31:24]
    logic [1:0]  s_tuser = 0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;       // out_value[15:0]
    logic        m_tuser;       // no_weight[0]
    logic        m_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    conv_scoreboard sb = new();
    bit  no_idle = 0;
    bit  pressure_go = 0;
    int  rand_items = 0;

    normalized_2d_convolution dut (.*);

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(action_t act, bit [7:0] idx, bit [15:0] cv, bit [7:0] pix);
        int gap;
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {pix, cv, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note(act, idx, cv, pix);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic reg_write(reg_index_t idx, bit [31:0] data);
        s_tvalid <= 0;
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        sb.write_reg(idx, data);
    endtask

    // Registers change only once the block has nothing in flight.
    task automatic wait_quiet();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (MAX_MASK * MAX_MASK + 40) @(posedge aclk);
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 2))
            0: send_item(ACT_COEF, 8'($urandom), 16'($urandom), 8'($urandom));
            1: send_item(ACT_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
            default: send_item(ACT_FLUSH, 8'($urandom), 16'($urandom), 8'($urandom));
        endcase
    endtask

    // One frame: configure, optionally reload the mask area, stream pixels, and drain unless truncated.
    task automatic run_frame(bit [31:0] iw_r, bit [31:0] ih_r, bit [31:0] mw_r,
                             bit [31:0] mh_r, bit [31:0] ax, bit [31:0] ay,
                             int coef_mode, bit truncate, ref int count);
        int unsigned iw, ih, mw, mh, npix, stop;
        bit [15:0]   cv;
        wait_quiet();
        reg_write(REG_IMAGE_WIDTH, iw_r);
        reg_write(REG_IMAGE_HEIGHT, ih_r);
        reg_write(REG_MASK_WIDTH, mw_r);
        reg_write(REG_MASK_HEIGHT, mh_r);
        reg_write(REG_ANCHOR_X, ax);
        reg_write(REG_ANCHOR_Y, ay);
        iw = sb.clampv(iw_r & 32'h7FF, MAX_WIDTH);
        ih = sb.clampv(ih_r & 32'h1FFF, MAX_HEIGHT);
        mw = sb.clampv(mw_r & 32'hF, MAX_MASK);
        mh = sb.clampv(mh_r & 32'hF, MAX_MASK);
        no_idle = ($urandom_range(0, 3) == 0);
        if (coef_mode != 0) begin
            for (int n = 0; n < mh; n++) begin
                for (int m = 0; m < mw; m++) begin
                    case (coef_mode)
                        1: cv = 16'($urandom);
                        2: cv = 0;
                        3: cv = 16'hFFFF;
                        default: cv = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0;
                    endcase
                    send_item(ACT_COEF, 8'(n * MAX_MASK + m), cv, 8'($urandom));
                    count++;
                end
            end
        end
        npix = iw * ih;
        stop = truncate ? $urandom_range(1, (npix < 64) ? npix : 64) : npix;
        for (int unsigned i = 0; i < stop; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                noise_item();
                count++;
            end
            send_item(ACT_PIXEL, 8'($urandom), 16'($urandom), 8'($urandom));
            count++;
        end
        if (truncate) return;
        // Pixels past the end of the frame behave as flushes.
        while (sb.frame_open) begin
            if ($urandom_range(0, 3) == 0)
                send_item(ACT_PIXEL, 8'($urandom), 16'($urandom), 8'($urandom));
            else
                send_item(ACT_FLUSH, 8'($urandom), 16'($urandom), 8'($urandom));
            count++;
        end
    endtask

    initial begin
        int          dummy;
        int unsigned mw, mh;
        dummy = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Every coefficient gets a value before any output can read it.
        for (int i = 0; i < COEF_COUNT; i++)
            send_item(ACT_COEF, 8'(i), (i == 0) ? 16'hFFFF : (i == 224) ? 16'h0
                      : 16'($urandom), 8'($urandom));
        send_item(ACT_COEF, 8'd225, 16'hFFFF, 8'hFF);
        send_item(ACT_COEF, 8'hFF, 16'h1234, 8'h00);
        send_item(ACT_NONE, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(ACT_FLUSH, 8'h00, 16'h0, 8'h00);

        // Small frame with extreme pixels, then border and anchor corners.
        wait_quiet();
        reg_write(REG_IMAGE_WIDTH, 4);
        reg_write(REG_IMAGE_HEIGHT, 3);
        reg_write(REG_MASK_WIDTH, 3);
        reg_write(REG_MASK_HEIGHT, 3);
        reg_write(REG_ANCHOR_X, 1);
        reg_write(REG_ANCHOR_Y, 1);
        for (int i = 0; i < 12; i++)
            send_item(ACT_PIXEL, 8'h0, 16'h0, (i % 2) ? 8'hFF : 8'h00);
        while (sb.frame_open) send_item(ACT_FLUSH, 8'h0, 16'h0, 8'h0);
        // An unused register index must leave everything alone.
        wait_quiet();
        reg_write(REG_SPARE6, 32'hFFFF_FFFF);
        reg_write(REG_SPARE7, 32'h0);
        run_frame(0, 0, 0, 0, 0, 0, 1, 0, dummy);
        run_frame(3, 2, 3, 3, 15, 15, 1, 0, dummy);
        run_frame(3, 3, 2, 2, 0, 0, 2, 0, dummy);
        run_frame(4, 4, 15, 15, 14, 14, 3, 0, dummy);
        run_frame(4, 3, 15, 15, 0, 0, 1, 0, dummy);
        run_frame(2047, 1, 3, 1, 1, 0, 1, 1, dummy);
        run_frame(1, 8191, 1, 3, 0, 1, 1, 1, dummy);
        run_frame(1024, 2, 1, 1, 0, 0, 1, 1, dummy);

        pressure_go = 1;
        while (rand_items < 500) begin
            mw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
            mh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
            run_frame($urandom_range(0, 9), $urandom_range(0, 7), mw, mh,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4),
                      $urandom_range(0, 4), ($urandom_range(0, 15) == 0), rand_items);
        end

        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        sb.mismatches += sb.pending.size();
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off.
    initial begin
        int gap;
        bit held;
        gap = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check(m_tdata, m_tuser, m_tlast);
            if (pressure_go && !held && sb.pending.size() != 0) begin
                held = 1;
                m_tready <= 0;
                repeat (4000) @(posedge aclk);
                m_tready <= 1;
            end else if (gap > 0) begin
                m_tready <= 0;
                gap--;
            end else begin
                m_tready <= 1;
                if ($urandom_range(0, 5) == 0)
                    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 3);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= 20000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end
endmodule

### normalized_2d_convolution.f
hw/rtl/n2c_pkg.sv
hw/rtl/n2c_regs.sv
hw/rtl/n2c_ctrl.sv
hw/rtl/n2c_dp.sv
hw/rtl/normalized_2d_convolution.sv
verif/tb.sv
